// File: design/rc4ok_pkg.sv
`default_nettype none
package rc4ok_pkg;

    localparam int MAX_KEY_BYTES  = 256;
    localparam int DISCARD_BYTES  = 256;
    localparam int PERM_DEPTH     = 256;
    localparam int BYTES_PER_WORD = 4;

    localparam int KCNT_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KADDR_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CNT_MAX = (DISCARD_BYTES > BYTES_PER_WORD) ? DISCARD_BYTES : BYTES_PER_WORD;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [7:0]  STEP_INC     = 8'd11;
    localparam logic [15:0] PATTERN_STEP = 16'd233;
    localparam logic [7:0]  J_MASK       = 8'h55;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_START,
        ST_KEY_RD,
        ST_KEY_RJ,
        ST_KEY_WN,
        ST_KEY_WJ,
        ST_KEY_FIN,
        ST_KEY_SET,
        ST_GEN_RI,
        ST_GEN_RJ,
        ST_GEN_WI,
        ST_GEN_WJ,
        ST_GEN_OUT,
        ST_PUT
    } eng_state_t;

    // one access slot of the permutation RAM per cycle
    typedef struct packed {
        logic       clear;
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } perm_req_t;

    // 233-step fill pattern: entry n holds 233*(n+1) mod 256
    function automatic logic [7:0] perm_init_value(input logic [7:0] n);
        logic [15:0] p;
        p = (16'(n) + 16'd1) * PATTERN_STEP;
        return p[7:0];
    endfunction

endpackage
`default_nettype wire

// File: design/rc4ok_perm_ram.sv
`default_nettype none
module rc4ok_perm_ram (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rc4ok_pkg::perm_req_t  req,
    output logic [7:0]                 rdata
);

    logic [7:0] perm_mem [rc4ok_pkg::PERM_DEPTH];
    logic [rc4ok_pkg::PERM_DEPTH-1:0] valid_reg;

    logic [7:0] mem_q_reg;
    logic       rvalid_reg;
    logic [7:0] raddr_reg;
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            perm_mem[req.waddr] <= req.wdata;
        end
        mem_q_reg    <= perm_mem[req.raddr];
        rvalid_reg   <= valid_reg[req.raddr];
        raddr_reg    <= req.raddr;
        fwd_data_reg <= req.wdata;
    end

    // entries never written since the last refill read as the fill pattern
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
        end else begin
            fwd_reg <= req.we && (req.waddr == req.raddr);
            if (req.clear) begin
                valid_reg <= '0;
            end else if (req.we) begin
                valid_reg[req.waddr] <= 1'b1;
            end
        end
    end

    always_comb begin
        if (fwd_reg) begin
            rdata = fwd_data_reg;
        end else if (rvalid_reg) begin
            rdata = mem_q_reg;
        end else begin
            rdata = rc4ok_pkg::perm_init_value(raddr_reg);
        end
    end

endmodule
`default_nettype wire

// File: design/rc4ok_key_store.sv
`default_nettype none
module rc4ok_key_store (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_valid,
    input  wire logic [7:0]                    wr_byte,
    input  wire logic                          count_clr,
    input  wire logic [rc4ok_pkg::KADDR_W-1:0] rd_addr,
    output logic [7:0]                         rd_data,
    output logic [rc4ok_pkg::KCNT_W-1:0]       count
);

    logic [7:0] key_mem [rc4ok_pkg::MAX_KEY_BYTES];
    logic [rc4ok_pkg::KCNT_W-1:0] count_reg;
    logic [7:0] rd_data_reg;
    logic       wr_en;

    // bytes past the store size are dropped
    assign wr_en = wr_valid &&
                   (count_reg < rc4ok_pkg::KCNT_W'(rc4ok_pkg::MAX_KEY_BYTES));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[count_reg[rc4ok_pkg::KADDR_W-1:0]] <= wr_byte;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (count_clr) begin
            count_reg <= '0;
        end else if (wr_en) begin
            count_reg <= count_reg + rc4ok_pkg::KCNT_W'(1);
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule
`default_nettype wire

// File: design/rc4ok_engine.sv
`default_nettype none
module rc4ok_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic                          s_kind,
    input  wire logic                          s_last,
    input  wire logic [rc4ok_pkg::KCNT_W-1:0]  key_count,
    input  wire logic [7:0]                    key_rd_data,
    output logic [rc4ok_pkg::KADDR_W-1:0]      key_rd_addr,
    output logic                               key_count_clr,
    output rc4ok_pkg::perm_req_t               perm_req,
    input  wire logic [7:0]                    perm_rdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata
);

    rc4ok_pkg::eng_state_t state_reg, state_next;

    logic [7:0]  i_reg, i_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  j_reg, j_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  n_reg, n_next;
    logic [rc4ok_pkg::KADDR_W-1:0] kidx_reg, kidx_next;
    logic [rc4ok_pkg::KCNT_W-1:0]  len_reg, len_next;
    logic [rc4ok_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic        gen_reg, gen_next;
    logic [31:0] word_reg, word_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rc4ok_pkg::ST_IDLE;
            i_reg         <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg        <= j_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        lo_reg       <= lo_next;
        n_reg        <= n_next;
        kidx_reg     <= kidx_next;
        len_reg      <= len_next;
        cnt_reg      <= cnt_next;
        gen_reg      <= gen_next;
        word_reg     <= word_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        acc_next       = acc_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        lo_next        = lo_reg;
        n_next         = n_reg;
        kidx_next      = kidx_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        gen_next       = gen_reg;
        word_next      = word_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        perm_req       = '0;
        key_count_clr  = 1'b0;
        s_tready       = 1'b0;

        case (state_reg)
            rc4ok_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_kind) begin
                        cnt_next   = rc4ok_pkg::CNT_W'(rc4ok_pkg::BYTES_PER_WORD);
                        gen_next   = 1'b1;
                        state_next = rc4ok_pkg::ST_GEN_RI;
                    end else if (s_last) begin
                        state_next = rc4ok_pkg::ST_KEY_START;
                    end
                end
            end
            rc4ok_pkg::ST_KEY_START: begin
                // key count already includes the last byte here, if the store had room for it
                len_next       = (key_count == '0) ? rc4ok_pkg::KCNT_W'(1) : key_count;
                key_count_clr  = 1'b1;
                perm_req.clear = 1'b1;
                n_next         = '0;
                j_next         = '0;
                kidx_next      = '0;
                state_next     = rc4ok_pkg::ST_KEY_RD;
            end
            rc4ok_pkg::ST_KEY_RD: begin
                perm_req.raddr = n_reg;
                state_next     = rc4ok_pkg::ST_KEY_RJ;
            end
            rc4ok_pkg::ST_KEY_RJ: begin
                a_next         = perm_rdata;
                j_next         = j_reg + perm_rdata + key_rd_data;
                perm_req.raddr = j_next;
                state_next     = rc4ok_pkg::ST_KEY_WN;
            end
            rc4ok_pkg::ST_KEY_WN: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = n_reg;
                perm_req.wdata = perm_rdata;
                state_next     = rc4ok_pkg::ST_KEY_WJ;
            end
            rc4ok_pkg::ST_KEY_WJ: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = a_reg;
                n_next         = n_reg + 8'd1;
                if ((rc4ok_pkg::KCNT_W'(kidx_reg) + rc4ok_pkg::KCNT_W'(1)) == len_reg) begin
                    kidx_next = '0;
                end else begin
                    kidx_next = kidx_reg + rc4ok_pkg::KADDR_W'(1);
                end
                if (n_reg == 8'hFF) begin
                    state_next = rc4ok_pkg::ST_KEY_FIN;
                end else begin
                    // next entry read overlaps this write; the RAM forwards on a match
                    perm_req.raddr = n_next;
                    state_next     = rc4ok_pkg::ST_KEY_RJ;
                end
            end
            rc4ok_pkg::ST_KEY_FIN: begin
                perm_req.raddr = j_reg ^ rc4ok_pkg::J_MASK;
                state_next     = rc4ok_pkg::ST_KEY_SET;
            end
            rc4ok_pkg::ST_KEY_SET: begin
                i_next   = perm_rdata;
                acc_next = '0;
                cnt_next = rc4ok_pkg::CNT_W'(rc4ok_pkg::DISCARD_BYTES);
                gen_next = 1'b0;
                if (rc4ok_pkg::DISCARD_BYTES == 0) begin
                    state_next = rc4ok_pkg::ST_IDLE;
                end else begin
                    state_next = rc4ok_pkg::ST_GEN_RI;
                end
            end
            rc4ok_pkg::ST_GEN_RI: begin
                i_next         = i_reg + rc4ok_pkg::STEP_INC;
                perm_req.raddr = i_next;
                state_next     = rc4ok_pkg::ST_GEN_RJ;
            end
            rc4ok_pkg::ST_GEN_RJ: begin
                a_next         = perm_rdata;
                acc_next       = {acc_reg[30:0], acc_reg[31]} + {24'd0, perm_rdata};
                lo_next        = acc_next[7:0];
                perm_req.raddr = lo_next;
                state_next     = rc4ok_pkg::ST_GEN_WI;
            end
            rc4ok_pkg::ST_GEN_WI: begin
                b_next         = perm_rdata;
                perm_req.we    = 1'b1;
                perm_req.waddr = i_reg;
                perm_req.wdata = perm_rdata;
                state_next     = rc4ok_pkg::ST_GEN_WJ;
            end
            rc4ok_pkg::ST_GEN_WJ: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = lo_reg;
                perm_req.wdata = a_reg;
                perm_req.raddr = a_reg + b_reg;
                state_next     = rc4ok_pkg::ST_GEN_OUT;
            end
            rc4ok_pkg::ST_GEN_OUT: begin
                if (gen_reg) begin
                    word_next = {word_reg[23:0], perm_rdata};
                end
                cnt_next = cnt_reg - rc4ok_pkg::CNT_W'(1);
                if (cnt_reg == rc4ok_pkg::CNT_W'(1)) begin
                    state_next = gen_reg ? rc4ok_pkg::ST_PUT : rc4ok_pkg::ST_IDLE;
                end else begin
                    i_next         = i_reg + rc4ok_pkg::STEP_INC;
                    perm_req.raddr = i_next;
                    state_next     = rc4ok_pkg::ST_GEN_RJ;
                end
            end
            rc4ok_pkg::ST_PUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = word_reg;
                    state_next     = rc4ok_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rc4ok_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        key_rd_addr = kidx_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc4ok_pkg::ST_IDLE) |-> !perm_req.we)
        else $error("permutation written while idle");

    a_put_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc4ok_pkg::ST_PUT && (!out_valid_reg || m_tready)) |=>
        (out_valid_reg && state_reg == rc4ok_pkg::ST_IDLE))
        else $error("finished word not moved to output register");

    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc4ok_pkg::ST_GEN_OUT) |-> (cnt_reg != '0))
        else $error("byte counter underflow");

    a_len_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc4ok_pkg::ST_KEY_WJ) |->
        (len_reg != '0 && rc4ok_pkg::KCNT_W'(kidx_reg) < len_reg))
        else $error("key index outside loaded key");

endmodule
`default_nettype wire

// File: design/rc4ok_keystream_generator.sv
`default_nettype none
// RC4OK keystream generator. Input transfers with s_tuser = 0 load one key byte
// (s_tdata) into the key store while it has room; s_tlast on such a byte starts
// keying, which refills the permutation, runs the key schedule and drops 256
// bytes before the next transfer is taken. A transfer with s_tuser = 1 yields
// one 32-bit word of four keystream bytes, earliest byte in bits 31..24, placed
// in the result register. Each keystream byte runs through GEN_RJ, GEN_WI, GEN_WJ
// and GEN_OUT because the permutation sits in a RAM with one read port and one
// write port and the byte needs two reads, two swap writes and a final read;
// a keying step runs through KEY_RJ, KEY_WN and KEY_WJ. Generating before any
// key uses the fill pattern with zero index and accumulator. The result
// register lets the next input be taken while a word still waits on m_tready.
module rc4ok_keystream_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] word
);

    rc4ok_pkg::perm_req_t             perm_req;
    logic [7:0]                       perm_rdata;
    logic [7:0]                       key_rd_data;
    logic [rc4ok_pkg::KADDR_W-1:0]    key_rd_addr;
    logic [rc4ok_pkg::KCNT_W-1:0]     key_count;
    logic                             key_count_clr;
    logic                             key_wr;

    assign key_wr = s_tvalid && s_tready && !s_tuser;

    rc4ok_key_store u_key_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_valid  (key_wr),
        .wr_byte   (s_tdata),
        .count_clr (key_count_clr),
        .rd_addr   (key_rd_addr),
        .rd_data   (key_rd_data),
        .count     (key_count)
    );

    rc4ok_perm_ram u_perm_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (perm_req),
        .rdata   (perm_rdata)
    );

    rc4ok_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_kind        (s_tuser),
        .s_last        (s_tlast),
        .key_count     (key_count),
        .key_rd_data   (key_rd_data),
        .key_rd_addr   (key_rd_addr),
        .key_count_clr (key_count_clr),
        .perm_req      (perm_req),
        .perm_rdata    (perm_rdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
`default_nettype wire

// File: test/keystream_tb_pkg.sv
`timescale 1ns / 100ps
package keystream_tb_pkg;

    // meaning of s_tuser on the input channel
    typedef enum logic {
        KIND_KEY = 1'b0,
        KIND_GEN = 1'b1
    } item_kind_t;

endpackage

// File: test/keystream_check.sv
`timescale 1ns / 100ps
module keystream_check (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_byte
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // [0] kind
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [31:0] word
    output int               err_count,
    output int               words_pending
);

    logic [7:0]  perm_tab [256];
    logic [7:0]  step_ix;
    logic [31:0] mix_acc;
    logic [7:0]  key_mem [256];
    logic [8:0]  key_len;
    logic [31:0] word_q [$];

    function automatic void load_pattern();
        logic [7:0] v;
        v = 8'd0;
        for (int n = 0; n < 256; n++) begin
            v = v + 8'(rc4ok_pkg::PATTERN_STEP);
            perm_tab[n] = v;
        end
    endfunction

    function automatic logic [7:0] next_ks_byte();
        logic [7:0] lo;
        logic [7:0] t;
        step_ix = step_ix + rc4ok_pkg::STEP_INC;
        mix_acc = {mix_acc[30:0], mix_acc[31]} + 32'(perm_tab[step_ix]);
        lo = mix_acc[7:0];
        t = perm_tab[step_ix];
        perm_tab[step_ix] = perm_tab[lo];
        perm_tab[lo] = t;
        return perm_tab[8'(perm_tab[step_ix] + perm_tab[lo])];
    endfunction

    always @(posedge aclk) begin : track
        logic [31:0] w;
        logic [7:0]  j;
        logic [7:0]  t;
        int          klen;
        if (!aresetn) begin
            load_pattern();
            step_ix = 8'd0;
            mix_acc = 32'd0;
            key_len = 9'd0;
            foreach (key_mem[n])
                key_mem[n] = 8'h00;
            word_q.delete();
            err_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (word_q.size() == 0) begin
                    $error("word: no transfer expected, actual 0x%08h", m_tdata);
                    err_count++;
                end else begin
                    w = word_q.pop_front();
                    if (m_tdata !== w) begin
                        $error("word: expected 0x%08h, actual 0x%08h", w, m_tdata);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (keystream_tb_pkg::item_kind_t'(s_tuser) == keystream_tb_pkg::KIND_GEN) begin
                    w = 32'd0;
                    // earliest keystream byte ends up in the top byte
                    repeat (4)
                        w = {w[23:0], next_ks_byte()};
                    word_q.push_back(w);
                end else begin
                    if (key_len < 9'(rc4ok_pkg::MAX_KEY_BYTES)) begin
                        key_mem[key_len[7:0]] = s_tdata;
                        key_len++;
                    end
                    if (s_tlast) begin
                        klen = (key_len == 9'd0) ? 1 : int'(key_len);
                        load_pattern();
                        j = 8'd0;
                        for (int n = 0; n < 256; n++) begin
                            j = j + perm_tab[n] + key_mem[n % klen];
                            t = perm_tab[n];
                            perm_tab[n] = perm_tab[j];
                            perm_tab[j] = t;
                        end
                        step_ix = perm_tab[j ^ rc4ok_pkg::J_MASK];
                        mix_acc = 32'd0;
                        repeat (rc4ok_pkg::DISCARD_BYTES)
                            void'(next_ks_byte());
                        key_len = 9'd0;
                    end
                end
            end
        end
        words_pending = word_q.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

    localparam int     RANDOM_ITEMS    = 1100;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     DRAIN_CYCLES    = 2500;  // covers one full keying pass
    localparam longint RUN_LIMIT_NS    = 20_000_000;
    localparam int     KEY_CAP         = rc4ok_pkg::MAX_KEY_BYTES;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] key_byte
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;    // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] word
    int          err_count;
    int          words_pending;

    bit gaps_on = 1'b1;
    bit hold_off_req = 1'b0;
    bit hold_active = 1'b0;
    int items_sent = 0;
    int key_fill = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    rc4ok_keystream_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    keystream_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .err_count     (err_count),
        .words_pending (words_pending)
    );

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input keystream_tb_pkg::item_kind_t kind,
                             input logic [7:0] kb, input logic last);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (gaps_on && r >= 60) begin
            if (r < 90)
                gap = $urandom_range(1, 3);
            else if (r < 98)
                gap = $urandom_range(4, 20);
            else
                gap = $urandom_range(30, 100);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= kb;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        // bytes past a full key store are dropped; only one with the last mark counts, as it starts keying
        if (kind == keystream_tb_pkg::KIND_GEN || key_fill < KEY_CAP || last)
            items_sent++;
        if (kind == keystream_tb_pkg::KIND_KEY) begin
            if (last)
                key_fill = 0;
            else if (key_fill < KEY_CAP)
                key_fill++;
        end
    endtask

    task automatic send_key(input int len, input int gen_at);
        for (int n = 0; n < len; n++) begin
            if (n == gen_at)
                send_item(keystream_tb_pkg::KIND_GEN, 8'($urandom), 1'($urandom));
            send_item(keystream_tb_pkg::KIND_KEY, 8'($urandom), n == len - 1);
        end
    endtask

    initial begin : receiver
        int  r;
        int  len;
        bit  held;
        held = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_active = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(1, 30);
                end else begin
                    m_tready <= 1'b0;
                    if (r < 85)
                        len = $urandom_range(1, 3);
                    else if (r < 95)
                        len = $urandom_range(4, 20);
                    else
                        len = $urandom_range(30, 120);
                end
                repeat (len) @(negedge aclk);
            end
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        int r;
        int sel;
        int len;
        int gen_at;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // words straight from the reset permutation, unused fields at extremes
        send_item(keystream_tb_pkg::KIND_GEN, 8'hFF, 1'b1);
        send_item(keystream_tb_pkg::KIND_GEN, 8'h00, 1'b0);
        // one-byte keys at both extremes of the byte
        send_item(keystream_tb_pkg::KIND_KEY, 8'h00, 1'b1);
        send_item(keystream_tb_pkg::KIND_GEN, 8'hA5, 1'b0);
        send_item(keystream_tb_pkg::KIND_KEY, 8'hFF, 1'b1);
        send_item(keystream_tb_pkg::KIND_GEN, 8'h5A, 1'b1);
        // generating in the middle of a key load keeps the partial key
        send_item(keystream_tb_pkg::KIND_KEY, 8'h12, 1'b0);
        send_item(keystream_tb_pkg::KIND_KEY, 8'h80, 1'b0);
        send_item(keystream_tb_pkg::KIND_KEY, 8'h7F, 1'b0);
        send_item(keystream_tb_pkg::KIND_GEN, 8'h00, 1'b1);
        send_item(keystream_tb_pkg::KIND_KEY, 8'h01, 1'b1);
        send_item(keystream_tb_pkg::KIND_GEN, 8'hFF, 1'b0);
        send_item(keystream_tb_pkg::KIND_GEN, 8'h00, 1'b0);

        // result side stalls long while generate transfers keep coming
        hold_off_req = 1'b1;
        wait (hold_active);
        @(negedge aclk);
        gaps_on = 1'b0;
        repeat (12)
            send_item(keystream_tb_pkg::KIND_GEN, 8'($urandom), 1'($urandom));
        gaps_on = 1'b1;

        items_sent = 0;
        // a key that exactly fills the store, then an overlong one
        send_key(KEY_CAP, -1);
        repeat (3)
            send_item(keystream_tb_pkg::KIND_GEN, 8'($urandom), 1'($urandom));
        send_key($urandom_range(KEY_CAP + 1, KEY_CAP + 40), $urandom_range(0, KEY_CAP));
        repeat (3)
            send_item(keystream_tb_pkg::KIND_GEN, 8'($urandom), 1'($urandom));

        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (r < 35) begin
                sel = $urandom_range(0, 99);
                if (sel < 1)
                    len = KEY_CAP;
                else if (sel < 2)
                    len = $urandom_range(KEY_CAP + 1, KEY_CAP + 30);
                else if (sel < 12)
                    len = $urandom_range(17, 64);
                else
                    len = $urandom_range(1, 16);
                gen_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
                send_key(len, gen_at);
                repeat ($urandom_range(1, 6))
                    send_item(keystream_tb_pkg::KIND_GEN, 8'($urandom), 1'($urandom));
            end else if (r < 85) begin
                repeat ($urandom_range(1, 8))
                    send_item(keystream_tb_pkg::KIND_GEN, 8'($urandom), 1'($urandom));
            end else begin
                send_item(keystream_tb_pkg::item_kind_t'($urandom_range(0, 1)),
                          8'($urandom), $urandom_range(0, 4) == 0);
            end
        end
        s_tvalid <= 1'b0;

        while (words_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: filelist.f
design/rc4ok_pkg.sv
design/rc4ok_perm_ram.sv
design/rc4ok_key_store.sv
design/rc4ok_engine.sv
design/rc4ok_keystream_generator.sv
test/keystream_tb_pkg.sv
test/keystream_check.sv
test/tb_top.sv
